FILE: sv/irc_pkg.sv
// Shared types and sizing constants for the I/O request coalescer.
// No dependencies; used by irc_merge, irc_out_queue and the top level.
`timescale 1ns / 1ps

package irc_pkg;

  localparam int MAX_SEGS    = 8;
  localparam int BATCH_SLOTS = 1024;

  localparam int FILE_W = 16;
  localparam int OFF_W  = 48;
  localparam int LEN_W  = 24;
  localparam int TOT_W  = 34;
  localparam int CNTO_W = 11;
  localparam int IDXO_W = 10;

  localparam int SEG_W  = $clog2(MAX_SEGS + 1);
  localparam int IDX_W  = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
  localparam int END_W  = OFF_W + 1;

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [FILE_W-1:0] file_id;
    logic              is_write;
    logic [OFF_W-1:0]  run_offset;
    logic [TOT_W-1:0]  run_total_length;
    logic [CNTO_W-1:0] segment_count;
    logic [IDXO_W-1:0] first_index;
    logic              last_of_batch;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       beat0;
    res_t       beat1;
  } push_t;

endpackage

FILE: sv/irc_merge.sv
// Open-run state and merge decision for the request coalescer.
// Depends on irc_pkg; feeds up to two result beats per request to irc_out_queue.
`timescale 1ns / 1ps

module irc_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [irc_pkg::FILE_W-1:0]  file_id,
  input  logic                        is_write,
  input  logic [irc_pkg::OFF_W-1:0]   byte_offset,
  input  logic [irc_pkg::LEN_W-1:0]   byte_length,
  input  logic                        end_of_batch,
  output irc_pkg::push_t              push
);

  logic                       open_valid_r, open_valid_nxt;
  logic [irc_pkg::FILE_W-1:0] open_file_r, open_file_nxt;
  logic                       open_write_r, open_write_nxt;
  logic [irc_pkg::OFF_W-1:0]  open_start_r, open_start_nxt;
  logic [irc_pkg::TOT_W-1:0]  open_total_r, open_total_nxt;
  logic [irc_pkg::SEG_W-1:0]  open_seg_r, open_seg_nxt;
  logic [irc_pkg::IDX_W-1:0]  open_first_r, open_first_nxt;
  logic [irc_pkg::IDX_W-1:0]  batch_idx_r, batch_idx_nxt;

  logic [irc_pkg::END_W-1:0]  run_end;
  logic                       joins;
  logic                       closes;
  irc_pkg::res_t              old_run;
  irc_pkg::res_t              cur_run;

  assign run_end = irc_pkg::END_W'(open_start_r) + irc_pkg::END_W'(open_total_r);

  assign joins = open_valid_r && (open_file_r == file_id) && (open_write_r == is_write) &&
                 (run_end == irc_pkg::END_W'(byte_offset)) &&
                 (open_seg_r < irc_pkg::SEG_W'(irc_pkg::MAX_SEGS));
  assign closes = open_valid_r && !joins;

  always_comb begin
    open_file_nxt  = open_file_r;
    open_write_nxt = open_write_r;
    open_start_nxt = open_start_r;
    open_total_nxt = open_total_r;
    open_seg_nxt   = open_seg_r;
    open_first_nxt = open_first_r;
    if (joins) begin
      open_total_nxt = open_total_r + irc_pkg::TOT_W'(byte_length);
      open_seg_nxt   = open_seg_r + 1'b1;
    end else begin
      open_file_nxt  = file_id;
      open_write_nxt = is_write;
      open_start_nxt = byte_offset;
      open_total_nxt = irc_pkg::TOT_W'(byte_length);
      open_seg_nxt   = irc_pkg::SEG_W'(1);
      open_first_nxt = batch_idx_r;
    end
  end

  always_comb begin
    old_run.file_id          = open_file_r;
    old_run.is_write         = open_write_r;
    old_run.run_offset       = open_start_r;
    old_run.run_total_length = open_total_r;
    old_run.segment_count    = irc_pkg::CNTO_W'(open_seg_r);
    old_run.first_index      = irc_pkg::IDXO_W'(open_first_r);
    old_run.last_of_batch    = 1'b0;

    cur_run.file_id          = open_file_nxt;
    cur_run.is_write         = open_write_nxt;
    cur_run.run_offset       = open_start_nxt;
    cur_run.run_total_length = open_total_nxt;
    cur_run.segment_count    = irc_pkg::CNTO_W'(open_seg_nxt);
    cur_run.first_index      = irc_pkg::IDXO_W'(open_first_nxt);
    cur_run.last_of_batch    = 1'b1;
  end

  // closed run goes out first, then the run that ends the batch
  always_comb begin
    push.count = 2'd0;
    if (accept) begin
      push.count = {1'b0, closes} + {1'b0, end_of_batch};
    end
    push.beat0 = closes ? old_run : cur_run;
    push.beat1 = cur_run;
  end

  always_comb begin
    if (batch_idx_r == irc_pkg::IDX_W'(irc_pkg::BATCH_SLOTS - 1)) begin
      batch_idx_nxt = '0;
    end else begin
      batch_idx_nxt = batch_idx_r + 1'b1;
    end
    open_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_valid_r <= 1'b0;
      open_file_r  <= '0;
      open_write_r <= 1'b0;
      open_start_r <= '0;
      open_total_r <= '0;
      open_seg_r   <= '0;
      open_first_r <= '0;
      batch_idx_r  <= '0;
    end else if (accept) begin
      if (end_of_batch) begin
        open_valid_r <= 1'b0;
        open_file_r  <= '0;
        open_write_r <= 1'b0;
        open_start_r <= '0;
        open_total_r <= '0;
        open_seg_r   <= '0;
        open_first_r <= '0;
        batch_idx_r  <= '0;
      end else begin
        open_valid_r <= open_valid_nxt;
        open_file_r  <= open_file_nxt;
        open_write_r <= open_write_nxt;
        open_start_r <= open_start_nxt;
        open_total_r <= open_total_nxt;
        open_seg_r   <= open_seg_nxt;
        open_first_r <= open_first_nxt;
        batch_idx_r  <= batch_idx_nxt;
      end
    end
  end

  a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_of_batch) |=> (!open_valid_r && batch_idx_r == '0))
    else $error("end of batch did not clear the open run");

  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    open_valid_r |-> (open_seg_r != '0 &&
                      open_seg_r <= irc_pkg::SEG_W'(irc_pkg::MAX_SEGS)))
    else $error("open run segment count out of range");

  a_join_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && joins && !end_of_batch) |=> (open_seg_r == $past(open_seg_r) + 1'b1))
    else $error("merged request did not extend the run");

endmodule

FILE: sv/irc_out_queue.sv
// Result queue: in, up to two beats per cycle; out, one per cycle if out_ready.
// Depends on irc_pkg; written by irc_merge.
`timescale 1ns / 1ps

module irc_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  irc_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output irc_pkg::res_t  head
);

  irc_pkg::res_t              entry_r [irc_pkg::QDEPTH];
  logic [irc_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [irc_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [irc_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic [irc_pkg::PTR_W-1:0]  wr_ptr_p1;
  logic                       pop;

  assign out_valid = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // leave space for a two-beat request
  assign room      = (count_r <= irc_pkg::QCNT_W'(irc_pkg::QDEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + irc_pkg::PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + irc_pkg::PTR_W'(pop);
    count_nxt  = count_r + irc_pkg::QCNT_W'(push.count) - irc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wr_ptr_r] <= push.beat0;
    end
    if (push.count == 2'd2) begin
      entry_r[wr_ptr_p1] <= push.beat1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= irc_pkg::QCNT_W'(irc_pkg::QDEPTH))
    else $error("result queue overflow");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.count == 2'd0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("result queue count lost a beat");

endmodule

FILE: sv/io_request_coalescer_unit.sv
// Top level of the I/O request coalescer: merge stage plus result queue.
// Depends on irc_pkg, irc_merge and irc_out_queue.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | file_id, is_write, byte_offset, byte_length, eob
//   out_    | output    | out_valid / out_ready | one merged run per beat
//
// One request per cycle while in_ready; its runs land in a 4-entry result queue the next cycle.
// A request that closes a run and ends the batch writes two beats at once.
// The queue drains one beat per cycle on out_ready; in_ready drops while it holds more than two.
// in_ready comes from the registered fill count, not from out_ready.
// Synchronous reset clears the open run, batch index and queue pointers.
`timescale 1ns / 1ps

module io_request_coalescer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [irc_pkg::FILE_W-1:0]  in_file_id,
  input  logic                        in_is_write,
  input  logic [irc_pkg::OFF_W-1:0]   in_byte_offset,
  input  logic [irc_pkg::LEN_W-1:0]   in_byte_length,
  input  logic                        in_end_of_batch,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [irc_pkg::FILE_W-1:0]  out_file_id,
  output logic                        out_is_write,
  output logic [irc_pkg::OFF_W-1:0]   out_run_offset,
  output logic [irc_pkg::TOT_W-1:0]   out_run_total_length,
  output logic [irc_pkg::CNTO_W-1:0]  out_segment_count,
  output logic [irc_pkg::IDXO_W-1:0]  out_first_index,
  output logic                        out_last_of_batch
);

  irc_pkg::push_t push;
  irc_pkg::res_t  head;
  logic           accept;

  assign accept = in_valid && in_ready;

  irc_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .file_id      (in_file_id),
    .is_write     (in_is_write),
    .byte_offset  (in_byte_offset),
    .byte_length  (in_byte_length),
    .end_of_batch (in_end_of_batch),
    .push         (push)
  );

  irc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_file_id          = head.file_id;
  assign out_is_write         = head.is_write;
  assign out_run_offset       = head.run_offset;
  assign out_run_total_length = head.run_total_length;
  assign out_segment_count    = head.segment_count;
  assign out_first_index      = head.first_index;
  assign out_last_of_batch    = head.last_of_batch;

endmodule
